// ===== hw/rtl/ip_address_text_validator_macros.svh =====
// assertion macros for the ip address text validator
// used by ip_address_text_validator.sv; expects clk and rst_n in scope
`ifndef IP_ADDRESS_TEXT_VALIDATOR_MACROS_SVH
`define IP_ADDRESS_TEXT_VALIDATOR_MACROS_SVH

// condition holds in the same cycle
`define IPAV_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition holds in the next cycle
`define IPAV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/ipav_pkg.sv =====
// shared types, character codes and helpers for the ip address text validator
// no dependencies
`default_nettype none

package ipav_pkg;

    localparam int KIND_W = 3;

    // result classification codes
    typedef enum logic [KIND_W-1:0] {
        KIND_INVALID = 3'd0,
        KIND_V4      = 3'd1,
        KIND_V6      = 3'd2,
        KIND_V6_LOOP = 3'd3,
        KIND_V6_ANY  = 3'd4
    } kind_t;

    localparam int PREFIX_DEPTH = 8;
    localparam int POS_W        = 4;

    // ascii codes
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_1     = 8'h31;
    localparam logic [7:0] CH_2     = 8'h32;
    localparam logic [7:0] CH_3     = 8'h33;
    localparam logic [7:0] CH_4     = 8'h34;
    localparam logic [7:0] CH_5     = 8'h35;
    localparam logic [7:0] CH_6     = 8'h36;
    localparam logic [7:0] CH_7     = 8'h37;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_COLON = 8'h3a;

    function automatic logic is_dec(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_dec(c) || ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ip_address_text_validator.sv =====
// ip address text validator: one character beat in, one result beat per string
// result: the beat marked last is taken into the input register, then its result into the output register
// throughput: one character per cycle, set by the single update stage; a last beat
// waits only while an untaken result sits in the output register
// reset: async active low; clears valid flags, counters and the prefix store
// depends on ipav_pkg and ip_address_text_validator_macros.svh
`default_nettype none

`include "ip_address_text_validator_macros.svh"

module ip_address_text_validator
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [7:0]                  char_code,
    input  wire logic                        char_present,
    input  wire logic                        last,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic                             valid_res,
    output logic [ipav_pkg::KIND_W-1:0]      kind,
    output logic                             is_private
);

    import ipav_pkg::*;

    // input register
    logic       in_vld_reg;
    logic [7:0] in_char_reg;
    logic       in_pres_reg;
    logic       in_last_reg;

    // stream state
    logic [POS_W-1:0] pos_reg;
    logic [7:0]       pre_reg [PREFIX_DEPTH];
    logic [1:0]       dot_reg;
    logic [1:0]       odig_reg;
    logic [9:0]       oval_reg;
    logic             v4_reg;
    logic [2:0]       col_reg;
    logic [2:0]       gdig_reg;
    logic             v6_reg;

    // state after the current character
    logic [POS_W-1:0] pos_next;
    logic [7:0]       pre_next [PREFIX_DEPTH];
    logic [1:0]       dot_next;
    logic [1:0]       odig_next;
    logic [9:0]       oval_next;
    logic             v4_next;
    logic [2:0]       col_next;
    logic [2:0]       gdig_next;
    logic             v6_next;
    logic [13:0]      oval_mul;

    // result
    logic  out_vld_reg;
    logic  valid_res_reg;
    kind_t kind_reg;
    logic  priv_reg;
    kind_t kind_next;
    logic  priv_next;
    logic  p10, p192, p127, p169, p172;

    logic adv;

    // handshake: a non-last beat never needs the output slot
    assign adv      = in_vld_reg && (!in_last_reg || !out_vld_reg || out_ready);
    assign in_ready = !in_vld_reg || adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_char_reg <= char_code;
            in_pres_reg <= char_present;
            in_last_reg <= last;
        end
    end

    // character update of both address forms and the prefix store
    always_comb
    begin
        pos_next  = pos_reg;
        dot_next  = dot_reg;
        odig_next = odig_reg;
        oval_next = oval_reg;
        v4_next   = v4_reg;
        col_next  = col_reg;
        gdig_next = gdig_reg;
        v6_next   = v6_reg;
        oval_mul  = 14'(oval_reg) * 14'd10 + 14'(in_char_reg - CH_0);
        for (int i = 0; i < PREFIX_DEPTH; i++)
        begin
            pre_next[i] = pre_reg[i];
            if (in_pres_reg && (pos_reg == POS_W'(i)))
            begin
                pre_next[i] = in_char_reg;
            end
        end
        if (in_pres_reg)
        begin
            if (pos_reg != {POS_W{1'b1}})
            begin
                pos_next = pos_reg + 1'b1;
            end
            // ipv4 tracking
            if (is_dec(in_char_reg))
            begin
                if (odig_reg == 2'd3)
                begin
                    v4_next = 1'b0;
                end
                else
                begin
                    odig_next = odig_reg + 1'b1;
                    oval_next = oval_mul[9:0];
                end
            end
            else if (in_char_reg == CH_DOT)
            begin
                if (odig_reg == 2'd0 || oval_reg > 10'd255 || dot_reg == 2'd3)
                begin
                    v4_next = 1'b0;
                end
                else
                begin
                    dot_next  = dot_reg + 1'b1;
                    odig_next = 2'd0;
                    oval_next = 10'd0;
                end
            end
            else
            begin
                v4_next = 1'b0;
            end
            // ipv6 eight-group tracking
            if (is_hex(in_char_reg))
            begin
                if (gdig_reg >= 3'd4)
                begin
                    v6_next = 1'b0;
                end
                else
                begin
                    gdig_next = gdig_reg + 1'b1;
                end
            end
            else if (in_char_reg == CH_COLON)
            begin
                if (gdig_reg == 3'd0 || col_reg == 3'd7)
                begin
                    v6_next = 1'b0;
                end
                else
                begin
                    col_next  = col_reg + 1'b1;
                    gdig_next = 3'd0;
                end
            end
            else
            begin
                v6_next = 1'b0;
            end
        end
    end

    // private prefix match on the updated prefix store
    always_comb
    begin
        p10  = (pos_next >= POS_W'(3)) && pre_next[0] == CH_1 && pre_next[1] == CH_0
            && pre_next[2] == CH_DOT;
        p127 = (pos_next >= POS_W'(4)) && pre_next[0] == CH_1 && pre_next[1] == CH_2
            && pre_next[2] == CH_7 && pre_next[3] == CH_DOT;
        p192 = (pos_next >= POS_W'(8)) && pre_next[0] == CH_1 && pre_next[1] == CH_9
            && pre_next[2] == CH_2 && pre_next[3] == CH_DOT && pre_next[4] == CH_1
            && pre_next[5] == CH_6 && pre_next[6] == 8'h38 && pre_next[7] == CH_DOT;
        p169 = (pos_next >= POS_W'(8)) && pre_next[0] == CH_1 && pre_next[1] == CH_6
            && pre_next[2] == CH_9 && pre_next[3] == CH_DOT && pre_next[4] == CH_2
            && pre_next[5] == CH_5 && pre_next[6] == CH_4 && pre_next[7] == CH_DOT;
        p172 = 1'b0;
        if ((pos_next >= POS_W'(7)) && pre_next[0] == CH_1 && pre_next[1] == CH_7
            && pre_next[2] == CH_2 && pre_next[3] == CH_DOT && pre_next[6] == CH_DOT)
        begin
            case (pre_next[4])
                CH_1:    p172 = (pre_next[5] >= CH_6) && (pre_next[5] <= CH_9);
                CH_2:    p172 = is_dec(pre_next[5]);
                CH_3:    p172 = (pre_next[5] == CH_0) || (pre_next[5] == CH_1);
                default: p172 = 1'b0;
            endcase
        end
        priv_next = p10 || p127 || p192 || p169 || p172;
    end

    // classification of the finished string
    always_comb
    begin
        if (v4_next && dot_next == 2'd3 && odig_next != 2'd0 && oval_next <= 10'd255)
        begin
            kind_next = KIND_V4;
        end
        else if (v6_next && col_next == 3'd7 && gdig_next != 3'd0)
        begin
            kind_next = KIND_V6;
        end
        else if (pos_next == POS_W'(3) && pre_next[0] == CH_COLON
                 && pre_next[1] == CH_COLON && pre_next[2] == CH_1)
        begin
            kind_next = KIND_V6_LOOP;
        end
        else if (pos_next == POS_W'(2) && pre_next[0] == CH_COLON
                 && pre_next[1] == CH_COLON)
        begin
            kind_next = KIND_V6_ANY;
        end
        else
        begin
            kind_next = KIND_INVALID;
        end
    end

    // state register: back to reset values after the last beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            dot_reg  <= '0;
            odig_reg <= '0;
            oval_reg <= '0;
            v4_reg   <= 1'b1;
            col_reg  <= '0;
            gdig_reg <= '0;
            v6_reg   <= 1'b1;
            for (int i = 0; i < PREFIX_DEPTH; i++)
            begin
                pre_reg[i] <= '0;
            end
        end
        else if (adv)
        begin
            if (in_last_reg)
            begin
                pos_reg  <= '0;
                dot_reg  <= '0;
                odig_reg <= '0;
                oval_reg <= '0;
                v4_reg   <= 1'b1;
                col_reg  <= '0;
                gdig_reg <= '0;
                v6_reg   <= 1'b1;
                for (int i = 0; i < PREFIX_DEPTH; i++)
                begin
                    pre_reg[i] <= '0;
                end
            end
            else
            begin
                pos_reg  <= pos_next;
                dot_reg  <= dot_next;
                odig_reg <= odig_next;
                oval_reg <= oval_next;
                v4_reg   <= v4_next;
                col_reg  <= col_next;
                gdig_reg <= gdig_next;
                v6_reg   <= v6_next;
                for (int i = 0; i < PREFIX_DEPTH; i++)
                begin
                    pre_reg[i] <= pre_next[i];
                end
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (adv && in_last_reg)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && in_last_reg)
        begin
            valid_res_reg <= (kind_next != KIND_INVALID);
            kind_reg      <= kind_next;
            priv_reg      <= priv_next;
        end
    end

    assign out_valid  = out_vld_reg;
    assign valid_res  = valid_res_reg;
    assign kind       = kind_reg;
    assign is_private = priv_reg;

    // checks
    `IPAV_ASSERT_NOW(a_valid_kind, out_vld_reg, (valid_res_reg == (kind_reg != KIND_INVALID)),
        "valid flag disagrees with kind")
    `IPAV_ASSERT_NEXT(a_last_gives_beat, adv && in_last_reg, out_vld_reg,
        "last beat did not produce a result")
    `IPAV_ASSERT_NEXT(a_last_clears, adv && in_last_reg,
        (pos_reg == '0) && v4_reg && v6_reg && (dot_reg == '0) && (col_reg == '0),
        "state not cleared after last beat")
    `IPAV_ASSERT_NOW(a_any_not_private, out_vld_reg && kind_reg == KIND_V6_ANY, !priv_reg,
        "bare double colon flagged private")

endmodule

`default_nettype wire
